/* rtl/ipthe_pkg.sv */
// ----------------------------------------------------------------------------
// ipthe_pkg
// Types and constants shared by the transport header extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipthe_pkg;

	// protocol numbers of interest
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// fixed byte positions in the ip header
	localparam logic [6:0] POS_IHL     = 7'd0;
	localparam logic [6:0] POS_TLEN_HI = 7'd2;
	localparam logic [6:0] POS_TLEN_LO = 7'd3;
	localparam logic [6:0] POS_PROTO   = 7'd9;

	// byte offsets from the start of the transport header
	localparam logic [6:0] OFF_SEQ_FIRST  = 7'd4;
	localparam logic [6:0] OFF_SEQ_LAST   = 7'd7;
	localparam logic [6:0] OFF_ULEN_HI    = 7'd4;
	localparam logic [6:0] OFF_ULEN_LO    = 7'd5;
	localparam logic [6:0] OFF_UDATA_FIRST = 7'd8;
	localparam logic [6:0] OFF_UDATA_LAST  = 7'd11;
	localparam logic [6:0] OFF_TCP_DOFF   = 7'd12;

	// byte position counter saturates here, well past every captured offset
	localparam logic [6:0] POS_MAX = 7'd127;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_TCP   = 2'd1,
		KIND_UDP   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [15:0] ip_total_length;
		logic [15:0] payload_length;
		logic [31:0] sequence_number;
		logic [1:0]  transport_kind;
	} result_item_t;

	// classified packet record passed from front to back
	typedef struct packed {
		logic [15:0] total_length;
		logic [6:0]  hdr_bytes;
		kind_t       kind;
		logic [31:0] seq;
		logic [15:0] udp_length;
	} pkt_rec_t;

endpackage

`default_nettype wire

/* rtl/ipthe_front.sv */
// ----------------------------------------------------------------------------
// ipthe_front
// Accepts packet bytes, captures header fields by offset and classifies the
// packet; pushes one record into the queue on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ipthe_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     byte_valid,
	input  ipthe_pkg::byte_item_t   byte_item,
	input  wire                     queue_full,
	output logic                    byte_stall,
	output logic                    push,
	output ipthe_pkg::pkt_rec_t     rec
);
	import ipthe_pkg::*;

	logic [6:0]  pos_q;
	logic [3:0]  ihl_q;
	logic [15:0] tlen_q;
	logic [7:0]  proto_q;
	logic [3:0]  doff_q;
	logic [31:0] seq_q;
	logic [15:0] ulen_q;
	logic [31:0] udata_q;

	logic [3:0]  ihl_n;
	logic [15:0] tlen_n;
	logic [7:0]  proto_n;
	logic [3:0]  doff_n;
	logic [31:0] seq_n;
	logic [15:0] ulen_n;
	logic [31:0] udata_n;

	logic [7:0]  diff;
	logic        in_xport;
	logic [6:0]  off;
	logic        accept;
	logic [7:0]  b;

	assign b          = byte_item.data_byte;
	assign byte_stall = queue_full;
	assign accept     = byte_valid && !queue_full;

	// offset within the transport header
	assign diff     = {1'b0, pos_q} - {2'b00, ihl_q, 2'b00};
	assign in_xport = !diff[7];
	assign off      = diff[6:0];

	// field capture for the current byte
	always_comb begin
		ihl_n   = ihl_q;
		tlen_n  = tlen_q;
		proto_n = proto_q;
		doff_n  = doff_q;
		seq_n   = seq_q;
		ulen_n  = ulen_q;
		udata_n = udata_q;
		if (pos_q == POS_IHL) begin
			ihl_n = b[3:0];
		end
		if (pos_q == POS_TLEN_HI) begin
			tlen_n[15:8] = b;
		end
		if (pos_q == POS_TLEN_LO) begin
			tlen_n[7:0] = b;
		end
		if (pos_q == POS_PROTO) begin
			proto_n = b;
		end
		if (in_xport) begin
			if (off >= OFF_SEQ_FIRST && off <= OFF_SEQ_LAST) begin
				case (off[1:0])
					2'd0:    seq_n[31:24] = b;
					2'd1:    seq_n[23:16] = b;
					2'd2:    seq_n[15:8]  = b;
					default: seq_n[7:0]   = b;
				endcase
			end
			if (off == OFF_ULEN_HI) begin
				ulen_n[15:8] = b;
			end
			if (off == OFF_ULEN_LO) begin
				ulen_n[7:0] = b;
			end
			if (off >= OFF_UDATA_FIRST && off <= OFF_UDATA_LAST) begin
				case (off[1:0])
					2'd0:    udata_n[31:24] = b;
					2'd1:    udata_n[23:16] = b;
					2'd2:    udata_n[15:8]  = b;
					default: udata_n[7:0]   = b;
				endcase
			end
			if (off == OFF_TCP_DOFF) begin
				doff_n = b[7:4];
			end
		end
	end

	// classify the packet from the updated fields
	always_comb begin
		rec.total_length = tlen_n;
		rec.hdr_bytes    = {1'b0, ihl_n, 2'b00} + {1'b0, doff_n, 2'b00};
		rec.udp_length   = ulen_n;
		if (proto_n == PROTO_TCP) begin
			rec.kind = KIND_TCP;
			rec.seq  = seq_n;
		end else if (proto_n == PROTO_UDP) begin
			rec.kind = KIND_UDP;
			rec.seq  = (ulen_n != 16'd0) ? udata_n : 32'd0;
		end else begin
			rec.kind = KIND_OTHER;
			rec.seq  = 32'd0;
		end
	end

	assign push = accept && byte_item.last_byte;

	// capture registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ihl_q   <= '0;
			tlen_q  <= '0;
			proto_q <= '0;
			doff_q  <= '0;
			seq_q   <= '0;
			ulen_q  <= '0;
			udata_q <= '0;
		end else if (accept) begin
			if (byte_item.last_byte) begin
				pos_q   <= '0;
				ihl_q   <= '0;
				tlen_q  <= '0;
				proto_q <= '0;
				doff_q  <= '0;
				seq_q   <= '0;
				ulen_q  <= '0;
				udata_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				ihl_q   <= ihl_n;
				tlen_q  <= tlen_n;
				proto_q <= proto_n;
				doff_q  <= doff_n;
				seq_q   <= seq_n;
				ulen_q  <= ulen_n;
				udata_q <= udata_n;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ipthe_queue.sv */
// ----------------------------------------------------------------------------
// ipthe_queue
// Short queue of packet records between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ipthe_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  ipthe_pkg::pkt_rec_t  push_rec,
	input  wire                  pop,
	output logic                 full,
	output logic                 not_empty,
	output ipthe_pkg::pkt_rec_t  head_rec
);
	import ipthe_pkg::*;

	pkt_rec_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_CW-1:0]     count_q;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_rec  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("item pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("item popped from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count did not follow push");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

endmodule

`default_nettype wire

/* rtl/ipthe_back.sv */
// ----------------------------------------------------------------------------
// ipthe_back
// Works out the payload length from a packet record and holds the result
// item in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipthe_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     rec_valid,
	input  ipthe_pkg::pkt_rec_t     rec,
	input  wire                     result_stall,
	output logic                    rec_pop,
	output logic                    result_valid,
	output ipthe_pkg::result_item_t result_item
);
	import ipthe_pkg::*;

	logic         valid_q;
	result_item_t item_q;
	result_item_t item_n;
	logic [15:0]  hdr_ext;
	logic         load;

	assign hdr_ext = {9'd0, rec.hdr_bytes};

	// payload length by kind, tcp clamped at zero
	always_comb begin
		item_n.ip_total_length = rec.total_length;
		item_n.sequence_number = rec.seq;
		item_n.transport_kind  = rec.kind;
		case (rec.kind)
			KIND_TCP: item_n.payload_length =
				(rec.total_length > hdr_ext) ? rec.total_length - hdr_ext : 16'd0;
			KIND_UDP: item_n.payload_length = rec.udp_length;
			default:  item_n.payload_length = 16'd0;
		endcase
	end

	assign load    = rec_valid && (!valid_q || !result_stall);
	assign rec_pop = load;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_n;
		end
	end

	assign result_valid = valid_q;
	assign result_item  = item_q;

endmodule

`default_nettype wire

/* rtl/ip_transport_header_extractor.sv */
// ----------------------------------------------------------------------------
// ip_transport_header_extractor
// Extracts ipv4 total length and tcp or udp payload length and sequence
// number from a byte stream, one result item per packet.
// ----------------------------------------------------------------------------
// throughput: one byte item per cycle while byte_stall is low, set by the front's per-byte capture
// the record is queued as the last byte is accepted, then loaded into the output register
// the two-entry record queue stalls input only when it is full
// reset: arst_n clears capture registers, queue pointers and output valid
`default_nettype none

module ip_transport_header_extractor (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     byte_valid,
	input  ipthe_pkg::byte_item_t   byte_item,
	output logic                    byte_stall,
	output logic                    result_valid,
	input  wire                     result_stall,
	output ipthe_pkg::result_item_t result_item
);
	import ipthe_pkg::*;

	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_not_empty;
	pkt_rec_t push_rec;
	pkt_rec_t head_rec;

	// byte capture and classification
	ipthe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.queue_full (q_full),
		.byte_stall (byte_stall),
		.push       (push),
		.rec        (push_rec)
	);

	// record queue
	ipthe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_rec  (head_rec)
	);

	// result computation and output register
	ipthe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (q_not_empty),
		.rec          (head_rec),
		.result_stall (result_stall),
		.rec_pop      (pop),
		.result_valid (result_valid),
		.result_item  (result_item)
	);

endmodule

`default_nettype wire

/* sim/ip_transport_header_extractor_tb.sv */
// ----------------------------------------------------------------------------
// ip_transport_header_extractor_tb
// Feeds ipv4 packets one byte item at a time. Directed packets come first:
// short packets, header length below five, tcp underflow, zero and full udp
// length, other protocols and one packet long enough to saturate the byte
// counter. Random packets follow, most of them well formed tcp or udp with
// random content and the rest noise or cut short. A scoreboard predicts the
// result item of every packet and checks each result field by field. The
// sender idles in bursts and the receiver stalls on its own pattern,
// including one long hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ip_transport_header_extractor_tb;
	import ipthe_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1080;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef logic [7:0] octet_q_t[$];

	// packet field predictor and store of expected result items
	class header_scoreboard;
		logic [15:0] pos;
		logic [3:0]  ihl;
		logic [15:0] tlen;
		logic [7:0]  proto;
		logic [3:0]  doff;
		logic [31:0] tcp_seq;
		logic [15:0] ulen;
		logic [31:0] udata;
		result_item_t expected_results[$];
		int errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			pos     = '0;
			ihl     = '0;
			tlen    = '0;
			proto   = '0;
			doff    = '0;
			tcp_seq = '0;
			ulen    = '0;
			udata   = '0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// update captured fields for one accepted byte item
		function void note_byte(byte_item_t it);
			int unsigned th;
			int unsigned off;
			int unsigned hdrs;
			result_item_t r;
			if (pos == 16'd0) ihl = it.data_byte[3:0];
			if (pos == 16'd2) tlen[15:8] = it.data_byte;
			if (pos == 16'd3) tlen[7:0] = it.data_byte;
			if (pos == 16'd9) proto = it.data_byte;
			th = 4 * ihl;
			if (pos >= th) begin
				off = pos - th;
				if (off >= 4 && off < 8)
					tcp_seq |= 32'(it.data_byte) << (24 - 8 * (off - 4));
				if (off == 4) ulen[15:8] = it.data_byte;
				if (off == 5) ulen[7:0] = it.data_byte;
				if (off >= 8 && off < 12)
					udata |= 32'(it.data_byte) << (24 - 8 * (off - 8));
				if (off == 12) doff = it.data_byte[7:4];
			end
			if (pos != 16'hffff) pos++;
			if (!it.last_byte) return;

			// packet complete: form the result item
			r = '0;
			r.ip_total_length = tlen;
			r.transport_kind = KIND_OTHER;
			if (proto == PROTO_TCP) begin
				hdrs = 4 * ihl + 4 * doff;
				r.transport_kind = KIND_TCP;
				r.payload_length = (tlen > hdrs) ? 16'(tlen - hdrs) : 16'd0;
				r.sequence_number = tcp_seq;
			end else if (proto == PROTO_UDP) begin
				r.transport_kind = KIND_UDP;
				r.payload_length = ulen;
				r.sequence_number = (ulen != 16'd0) ? udata : 32'd0;
			end
			expected_results.push_back(r);
			clear();
		endfunction

		// compare one accepted result item with the oldest expectation
		function void check_result(result_item_t got);
			result_item_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.ip_total_length !== exp_r.ip_total_length) begin
				$display("%0t: ip_total_length expected %h actual %h",
					$time, exp_r.ip_total_length, got.ip_total_length);
				errors++;
			end
			if (got.payload_length !== exp_r.payload_length) begin
				$display("%0t: payload_length expected %h actual %h",
					$time, exp_r.payload_length, got.payload_length);
				errors++;
			end
			if (got.sequence_number !== exp_r.sequence_number) begin
				$display("%0t: sequence_number expected %h actual %h",
					$time, exp_r.sequence_number, got.sequence_number);
				errors++;
			end
			if (got.transport_kind !== exp_r.transport_kind) begin
				$display("%0t: transport_kind expected %h actual %h",
					$time, exp_r.transport_kind, got.transport_kind);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         byte_valid = 1'b0;
	byte_item_t   byte_item = '0;
	logic         byte_stall;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;

	header_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;

	ip_transport_header_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_item    (byte_item),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always #6 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) sb.note_byte(byte_item);
		if (arst_n && result_valid && !result_stall) sb.check_result(result_item);
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin : receiver
		int unsigned mode;
		int unsigned left;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= ((left % 8) < 4);
			endcase
		end
	end

	// offer one byte item, with a random gap between bursts
	task automatic send_byte(input logic [7:0] d, input logic l);
		if (burst_left == 0) begin
			if (gaps_on) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		byte_item <= '{data_byte: d, last_byte: l};
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_packet(input octet_q_t p);
		foreach (p[i]) send_byte(p[i], i == p.size() - 1);
	endtask

	// packet with header fields placed where they fit; fill < 0 means random body and fields, else every byte is fill
	function automatic octet_q_t build_packet(int unsigned len, logic [3:0] ihl,
			logic [7:0] proto, logic [15:0] tlen, logic [3:0] doff,
			logic [15:0] ulen, int fill);
		octet_q_t p;
		int unsigned th;
		for (int unsigned i = 0; i < len; i++)
			p.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		th = 4 * ihl;
		if (fill < 0) begin
			if (len > 0) p[0] = {4'h4, ihl};
			if (len > 3) begin
				p[2] = tlen[15:8];
				p[3] = tlen[7:0];
			end
			if (len > 9) p[9] = proto;
			if (proto == PROTO_UDP && th + 5 < len) begin
				p[th + 4] = ulen[15:8];
				p[th + 5] = ulen[7:0];
			end
			if (proto == PROTO_TCP && th + 12 < len)
				p[th + 12] = {doff, p[th + 12][3:0]};
		end
		return p;
	endfunction

	// one random packet, mostly well formed
	task automatic send_random_packet();
		int unsigned kind_pick;
		int unsigned len;
		logic [3:0]  ihl;
		logic [3:0]  doff;
		logic [7:0]  proto;
		logic [15:0] tlen;
		logic [15:0] ulen;
		octet_q_t p;
		kind_pick = $urandom_range(0, 99);
		ihl  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
		doff = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
		gaps_on = ($urandom_range(0, 3) != 0);
		if (kind_pick < 80) begin
			proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
			if (proto == PROTO_TCP)
				len = 4 * ihl + 4 * doff + $urandom_range(0, 12);
			else
				len = 4 * ihl + 8 + $urandom_range(0, 12);
			if (len < 10) len = 10;
			tlen = ($urandom_range(0, 3) != 0) ? 16'(len) : 16'($urandom);
			case ($urandom_range(0, 5))
				0: ulen = 16'd0;
				1: ulen = 16'($urandom);
				default: ulen = 16'(len - 4 * ihl);
			endcase
			// some packets are cut short
			if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
		end else begin
			len = $urandom_range(1, 20);
			case ($urandom_range(0, 2))
				0: proto = PROTO_TCP;
				1: proto = PROTO_UDP;
				default: proto = 8'($urandom);
			endcase
			ihl  = 4'($urandom);
			tlen = 16'($urandom);
			ulen = 16'($urandom);
		end
		p = build_packet(len, ihl, proto, tlen, doff, ulen, -1);
		send_packet(p);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets
		send_packet(build_packet(1, 4'd5, PROTO_TCP, 16'd40, 4'd5, 16'd0, -1));
		send_packet(build_packet(9, 4'd5, PROTO_TCP, 16'd40, 4'd5, 16'd0, -1));
		send_packet(build_packet(44, 4'd5, PROTO_TCP, 16'd44, 4'd5, 16'd0, -1));
		// tcp headers longer than the total length
		send_packet(build_packet(40, 4'd5, PROTO_TCP, 16'd20, 4'd5, 16'd0, -1));
		send_packet(build_packet(32, 4'd5, PROTO_UDP, 16'd32, 4'd0, 16'd0, -1));
		send_packet(build_packet(32, 4'd5, PROTO_UDP, 16'hffff, 4'd0, 16'hffff, -1));
		send_packet(build_packet(24, 4'd5, 8'd1, 16'hffff, 4'd0, 16'd0, -1));
		// header length below five, transport fields overlap the ip header
		send_packet(build_packet(20, 4'd0, PROTO_TCP, 16'd20, 4'd15, 16'd0, -1));
		send_packet(build_packet(24, 4'd1, PROTO_UDP, 16'd24, 4'd0, 16'd12, -1));
		send_packet(build_packet(20, 4'd4, PROTO_UDP, 16'd20, 4'd0, 16'd1, -1));
		send_packet(build_packet(124, 4'd15, PROTO_TCP, 16'hffff, 4'd15, 16'd0, -1));
		// long packet, past the byte counter saturation
		send_packet(build_packet(300, 4'd5, PROTO_TCP, 16'd300, 4'd5, 16'd0, -1));
		send_packet(build_packet(20, 4'd0, 8'd0, 16'd0, 4'd0, 16'd0, 0));
		send_packet(build_packet(80, 4'd0, 8'd0, 16'd0, 4'd0, 16'd0, 255));

		// long receiver hold-off while the sender keeps offering
		gaps_on = 1'b0;
		hold_req = 1'b1;
		send_packet(build_packet(30, 4'd5, PROTO_UDP, 16'd30, 4'd0, 16'd10, -1));
		while (hold_req) send_packet(build_packet($urandom_range(1, 12), 4'd5,
			PROTO_TCP, 16'($urandom), 4'd5, 16'd0, -1));

		// random packets
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) send_random_packet();
		byte_valid <= 1'b0;

		// let the monitor note the final byte before polling
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
rtl/ipthe_pkg.sv
rtl/ipthe_front.sv
rtl/ipthe_queue.sv
rtl/ipthe_back.sv
rtl/ip_transport_header_extractor.sv
sim/ip_transport_header_extractor_tb.sv
